[design/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define RFN_CHECK(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("rfn check failed");

// Next-cycle implication, disabled while reset is low.
`define RFN_CHECK_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("rfn check failed");

`endif

[design/rfn_pkg.sv]
package rfn_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CHILDREN_DEF   = 4;

    localparam logic [1:0] FUNC_FLAT   = 2'd0;
    localparam logic [1:0] FUNC_PARENT = 2'd1;
    localparam logic [1:0] FUNC_CHILD  = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_NRM,
        S_LEN,
        S_BIG,
        S_DIV,
        S_SQRT,
        S_CNT,
        S_EMIT
    } t_state;

endpackage

[design/rfn_in_if.sv]
interface rfn_in_if #(
    parameter int COORD_BITS = rfn_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   func;
    logic signed [COORD_BITS-1:0] x0;
    logic signed [COORD_BITS-1:0] y0;
    logic signed [COORD_BITS-1:0] z0;
    logic signed [COORD_BITS-1:0] x1;
    logic signed [COORD_BITS-1:0] y1;
    logic signed [COORD_BITS-1:0] z1;
    logic signed [COORD_BITS-1:0] x2;
    logic signed [COORD_BITS-1:0] y2;
    logic signed [COORD_BITS-1:0] z2;

    modport source(output valid, func, x0, y0, z0, x1, y1, z1, x2, y2, z2, input ready);
    modport sink(input valid, func, x0, y0, z0, x1, y1, z1, x2, y2, z2, output ready);
endinterface

[design/rfn_out_if.sv]
interface rfn_out_if #(
    parameter int FRAC_BITS = rfn_pkg::FRAC_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] curvature;
    logic               mark;
    logic               degenerate;

    modport source(output valid, curvature, mark, degenerate, input ready);
    modport sink(input valid, curvature, mark, degenerate, output ready);
endinterface

[design/rfn_cfg_if.sv]
interface rfn_cfg_if #(
    parameter int FRAC_BITS = rfn_pkg::FRAC_BITS_DEF
);
    logic               valid;
    logic               ready;
    logic [FRAC_BITS:0] threshold;

    modport source(output valid, threshold, input ready);
    modport sink(input valid, threshold, output ready);
endinterface

[design/rfn_mul.sv]
module rfn_mul #(
    parameter int MB = 2 * rfn_pkg::COORD_BITS_DEF + 4
) (
    input  logic                   i_clk,
    input  logic signed [MB-1:0]   i_a,
    input  logic signed [MB-1:0]   i_b,
    output logic signed [2*MB-1:0] o_p
);
    logic signed [2*MB-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

[design/refinement_flag_by_normal_deviation_unit.sv]
// Refinement mark from normal deviation.
// i_in takes one triangle a beat: func 0 a lone unrefined triangle, 1 a parent,
// 2 a child; func 3 is taken and dropped. o_out gives one beat after a lone
// triangle and one after the CHILDREN-th child: the minimum absolute cosine
// between child and parent normals (Q1.FRAC_BITS), the mark (curvature below
// threshold) and the degenerate flag. i_cfg writes the threshold at any beat.
// A lone triangle goes to the output load, a parent only forms its normal, and
// a child forms its normal, lengths and dot product, then divides and takes the
// root unless a normal has zero length; the last child then loads the output.
// All products go through one registered multiplier, the quotient comes from a
// restoring divider (one bit a cycle) and the cosine from a digit-by-digit
// square root (one bit a cycle). i_in.ready is high only while the sequencer
// is idle. A finished beat sits in the output register; the next item is
// taken while it waits, and a stalled receiver stops the block only when a
// second result is ready. Reset drops any pending beat, clears the parent,
// sets the running minimum to one and loads the threshold with 0.99.
`include "assert_macros.svh"

module refinement_flag_by_normal_deviation_unit #(
    parameter int COORD_BITS = rfn_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = rfn_pkg::FRAC_BITS_DEF,
    parameter int CHILDREN   = rfn_pkg::CHILDREN_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rfn_in_if.sink    i_in,
    rfn_out_if.source o_out,
    rfn_cfg_if.sink   i_cfg
);
    localparam int DB   = COORD_BITS + 1;
    localparam int NB   = 2 * COORD_BITS + 3;
    localparam int MB   = NB + 1;
    localparam int PRB  = 2 * MB;
    localparam int LB   = 2 * NB;
    localparam int PB   = 2 * LB;
    localparam int QB   = 2 * FRAC_BITS + 1;
    localparam int RB   = FRAC_BITS + 1;
    localparam int SRB  = FRAC_BITS + 5;
    localparam int CNTB = $clog2(CHILDREN + 1);
    localparam int SB   = $clog2(QB + 1);
    localparam longint unsigned THR_L = ((64'd99 << FRAC_BITS) + 64'd50) / 64'd100;
    localparam logic [RB-1:0] THR_RST = THR_L[RB-1:0];
    localparam logic [RB-1:0] ONE     = RB'(1) << FRAC_BITS;

    rfn_pkg::t_state r_state, n_state;
    logic [SB-1:0]   r_step, n_step;

    logic signed [DB-1:0] r_da [3];
    logic signed [DB-1:0] r_db [3];
    logic signed [NB-1:0] r_cn [3];
    logic signed [NB-1:0] r_pn [3];
    logic                 r_is_parent;
    logic [LB-1:0]        r_lp, r_lc, r_dmag;
    logic signed [LB:0]   r_dot;
    logic [PB-1:0]        r_dsq, r_prd;
    logic [PB:0]          r_rem;
    logic [QB:0]          r_q;
    logic [SRB-1:0]       r_srem;
    logic [RB-1:0]        r_root;
    logic                 r_skip;
    logic [RB-1:0]        r_min;
    logic                 r_deg;
    logic [CNTB-1:0]      r_cnt;
    logic [RB-1:0]        r_thr;
    logic                 r_ovld;
    logic [RB-1:0]        r_ocurv;
    logic                 r_omark, r_odeg;

    logic signed [MB-1:0]  w_ma, w_mb;
    logic signed [PRB-1:0] w_p;
    logic [PB-1:0]         w_pu;
    logic                  w_accept, w_load, w_lzero, w_last;
    logic signed [LB:0]    w_dabs;
    logic [PB:0]           w_t;
    logic                  w_ge;
    logic [SRB-1:0]        w_rem2, w_trial;
    logic                  w_sge;

    rfn_mul #(.MB(MB)) u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    assign w_accept = i_in.valid && (r_state == rfn_pkg::S_IDLE);
    assign w_load   = (r_state == rfn_pkg::S_EMIT) && (!r_ovld || o_out.ready);
    assign w_lzero  = (r_lp == '0) || (r_lc == '0);
    assign w_last   = (r_cnt == CNTB'(CHILDREN - 1));
    assign w_pu     = PB'(w_p[LB-1:0]);
    assign w_dabs   = r_dot[LB] ? -r_dot : r_dot;
    assign w_t      = (r_step == '0) ? r_rem : (r_rem << 1);
    assign w_ge     = (w_t >= {1'b0, r_prd});
    assign w_rem2   = {r_srem[SRB-3:0], r_q[QB:QB-1]};
    assign w_trial  = SRB'({r_root, 2'b01});
    assign w_sge    = (w_rem2 >= w_trial);

    assign i_in.ready       = (r_state == rfn_pkg::S_IDLE);
    assign i_cfg.ready      = 1'b1;
    assign o_out.valid      = r_ovld;
    assign o_out.curvature  = r_ocurv;
    assign o_out.mark       = r_omark;
    assign o_out.degenerate = r_odeg;

    // operand select for the shared multiplier
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            rfn_pkg::S_NRM: begin
                case (r_step)
                    SB'(0): begin w_ma = MB'(r_da[1]); w_mb = MB'(r_db[2]); end
                    SB'(1): begin w_ma = MB'(r_da[2]); w_mb = MB'(r_db[1]); end
                    SB'(2): begin w_ma = MB'(r_da[2]); w_mb = MB'(r_db[0]); end
                    SB'(3): begin w_ma = MB'(r_da[0]); w_mb = MB'(r_db[2]); end
                    SB'(4): begin w_ma = MB'(r_da[0]); w_mb = MB'(r_db[1]); end
                    SB'(5): begin w_ma = MB'(r_da[1]); w_mb = MB'(r_db[0]); end
                    default: ;
                endcase
            end
            rfn_pkg::S_LEN: begin
                case (r_step)
                    SB'(0): begin w_ma = MB'(r_pn[0]); w_mb = MB'(r_pn[0]); end
                    SB'(1): begin w_ma = MB'(r_pn[1]); w_mb = MB'(r_pn[1]); end
                    SB'(2): begin w_ma = MB'(r_pn[2]); w_mb = MB'(r_pn[2]); end
                    SB'(3): begin w_ma = MB'(r_cn[0]); w_mb = MB'(r_cn[0]); end
                    SB'(4): begin w_ma = MB'(r_cn[1]); w_mb = MB'(r_cn[1]); end
                    SB'(5): begin w_ma = MB'(r_cn[2]); w_mb = MB'(r_cn[2]); end
                    SB'(6): begin w_ma = MB'(r_pn[0]); w_mb = MB'(r_cn[0]); end
                    SB'(7): begin w_ma = MB'(r_pn[1]); w_mb = MB'(r_cn[1]); end
                    SB'(8): begin w_ma = MB'(r_pn[2]); w_mb = MB'(r_cn[2]); end
                    default: ;
                endcase
            end
            rfn_pkg::S_BIG: begin
                case (r_step)
                    SB'(0): begin
                        w_ma = {1'b0, r_dmag[NB-1:0]};
                        w_mb = {1'b0, r_dmag[NB-1:0]};
                    end
                    SB'(1): begin
                        w_ma = {1'b0, r_dmag[NB-1:0]};
                        w_mb = {1'b0, r_dmag[LB-1:NB]};
                    end
                    SB'(2): begin
                        w_ma = {1'b0, r_dmag[LB-1:NB]};
                        w_mb = {1'b0, r_dmag[NB-1:0]};
                    end
                    SB'(3): begin
                        w_ma = {1'b0, r_dmag[LB-1:NB]};
                        w_mb = {1'b0, r_dmag[LB-1:NB]};
                    end
                    SB'(4): begin
                        w_ma = {1'b0, r_lp[NB-1:0]};
                        w_mb = {1'b0, r_lc[NB-1:0]};
                    end
                    SB'(5): begin
                        w_ma = {1'b0, r_lp[NB-1:0]};
                        w_mb = {1'b0, r_lc[LB-1:NB]};
                    end
                    SB'(6): begin
                        w_ma = {1'b0, r_lp[LB-1:NB]};
                        w_mb = {1'b0, r_lc[NB-1:0]};
                    end
                    SB'(7): begin
                        w_ma = {1'b0, r_lp[LB-1:NB]};
                        w_mb = {1'b0, r_lc[LB-1:NB]};
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            rfn_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    case (i_in.func)
                        rfn_pkg::FUNC_FLAT: n_state = rfn_pkg::S_EMIT;
                        rfn_pkg::FUNC_PARENT: begin
                            n_state = rfn_pkg::S_NRM;
                            n_step  = '0;
                        end
                        rfn_pkg::FUNC_CHILD: begin
                            n_state = rfn_pkg::S_NRM;
                            n_step  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            rfn_pkg::S_NRM: begin
                if (r_step == SB'(7)) begin
                    n_state = r_is_parent ? rfn_pkg::S_IDLE : rfn_pkg::S_LEN;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rfn_pkg::S_LEN: begin
                if (r_step == SB'(10)) begin
                    n_state = w_lzero ? rfn_pkg::S_CNT : rfn_pkg::S_BIG;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rfn_pkg::S_BIG: begin
                if (r_step == SB'(9)) begin
                    n_state = rfn_pkg::S_DIV;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rfn_pkg::S_DIV: begin
                if (r_step == SB'(QB - 1)) begin
                    n_state = rfn_pkg::S_SQRT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rfn_pkg::S_SQRT: begin
                if (r_step == SB'(FRAC_BITS)) begin
                    n_state = rfn_pkg::S_CNT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            rfn_pkg::S_CNT: n_state = w_last ? rfn_pkg::S_EMIT : rfn_pkg::S_IDLE;
            rfn_pkg::S_EMIT: begin
                if (w_load) begin
                    n_state = rfn_pkg::S_IDLE;
                end
            end
            default: n_state = rfn_pkg::S_IDLE;
        endcase
    end

    // control state and the sequence that a parent opens
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rfn_pkg::S_IDLE;
            r_step  <= '0;
            r_thr   <= THR_RST;
            r_pn    <= '{default: '0};
            r_min   <= ONE;
            r_cnt   <= '0;
            r_deg   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            if (i_cfg.valid) begin
                r_thr <= i_cfg.threshold;
            end
            if (o_out.ready && !w_load) begin
                r_ovld <= 1'b0;
            end
            if (w_accept && (i_in.func == rfn_pkg::FUNC_FLAT
                             || i_in.func == rfn_pkg::FUNC_PARENT)) begin
                r_pn  <= '{default: '0};
                r_min <= ONE;
                r_cnt <= '0;
                r_deg <= 1'b0;
            end
            if (r_state == rfn_pkg::S_NRM && r_step == SB'(7) && r_is_parent) begin
                r_pn <= r_cn;
            end
            if (r_state == rfn_pkg::S_LEN && r_step == SB'(10) && w_lzero) begin
                r_deg <= 1'b1;
            end
            if (r_state == rfn_pkg::S_CNT) begin
                if (!r_skip && r_root < r_min) begin
                    r_min <= r_root;
                end
                // hold the count on the last child, the output load clears it
                if (!w_last) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (w_load) begin
                r_ovld <= 1'b1;
                r_pn   <= '{default: '0};
                r_min  <= ONE;
                r_cnt  <= '0;
                r_deg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_da[0]     <= DB'(i_in.x1) - DB'(i_in.x0);
            r_da[1]     <= DB'(i_in.y1) - DB'(i_in.y0);
            r_da[2]     <= DB'(i_in.z1) - DB'(i_in.z0);
            r_db[0]     <= DB'(i_in.x2) - DB'(i_in.x0);
            r_db[1]     <= DB'(i_in.y2) - DB'(i_in.y0);
            r_db[2]     <= DB'(i_in.z2) - DB'(i_in.z0);
            r_is_parent <= (i_in.func == rfn_pkg::FUNC_PARENT);
        end

        case (r_state)
            rfn_pkg::S_NRM: begin
                // product of step k arrives at step k+1
                case (r_step)
                    SB'(1): r_cn[0] <= w_p[NB-1:0];
                    SB'(2): r_cn[0] <= r_cn[0] - $signed(w_p[NB-1:0]);
                    SB'(3): r_cn[1] <= w_p[NB-1:0];
                    SB'(4): r_cn[1] <= r_cn[1] - $signed(w_p[NB-1:0]);
                    SB'(5): r_cn[2] <= w_p[NB-1:0];
                    SB'(6): r_cn[2] <= r_cn[2] - $signed(w_p[NB-1:0]);
                    default: ;
                endcase
            end
            rfn_pkg::S_LEN: begin
                if (r_step == '0) begin
                    r_lp  <= '0;
                    r_lc  <= '0;
                    r_dot <= '0;
                end else if (r_step <= SB'(3)) begin
                    r_lp <= r_lp + w_p[LB-1:0];
                end else if (r_step <= SB'(6)) begin
                    r_lc <= r_lc + w_p[LB-1:0];
                end else if (r_step <= SB'(9)) begin
                    r_dot <= r_dot + $signed(w_p[LB:0]);
                end else begin
                    r_dmag <= w_dabs[LB-1:0];
                    r_skip <= w_lzero;
                end
            end
            rfn_pkg::S_BIG: begin
                case (r_step)
                    SB'(0): begin
                        r_dsq <= '0;
                        r_prd <= '0;
                    end
                    SB'(1): r_dsq <= r_dsq + w_pu;
                    SB'(2): r_dsq <= r_dsq + (w_pu << NB);
                    SB'(3): r_dsq <= r_dsq + (w_pu << NB);
                    SB'(4): r_dsq <= r_dsq + (w_pu << LB);
                    SB'(5): r_prd <= r_prd + w_pu;
                    SB'(6): r_prd <= r_prd + (w_pu << NB);
                    SB'(7): r_prd <= r_prd + (w_pu << NB);
                    SB'(8): r_prd <= r_prd + (w_pu << LB);
                    default: begin
                        r_rem <= {1'b0, r_dsq};
                        r_q   <= '0;
                    end
                endcase
            end
            rfn_pkg::S_DIV: begin
                r_rem <= w_ge ? (w_t - {1'b0, r_prd}) : w_t;
                r_q   <= {r_q[QB-1:0], w_ge};
                if (r_step == SB'(QB - 1)) begin
                    r_srem <= '0;
                    r_root <= '0;
                end
            end
            rfn_pkg::S_SQRT: begin
                r_srem <= w_sge ? (w_rem2 - w_trial) : w_rem2;
                r_root <= {r_root[RB-2:0], w_sge};
                r_q    <= r_q << 2;
            end
            default: ;
        endcase

        if (w_load) begin
            r_ocurv <= r_min;
            r_omark <= (r_min < r_thr);
            r_odeg  <= r_deg;
        end
    end

    `RFN_CHECK(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt < CNTB'(CHILDREN))
    `RFN_CHECK(a_div_rem, i_clk, i_rst_n, r_state == rfn_pkg::S_DIV, r_rem <= (PB+1)'(r_prd))
    `RFN_CHECK(a_root_max, i_clk, i_rst_n, r_state == rfn_pkg::S_CNT && !r_skip, r_root <= ONE)
    `RFN_CHECK_NEXT(a_load_valid, i_clk, i_rst_n, w_load, r_ovld)
endmodule
